[design/lsbr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsbr_pkg
// Shared types and constants of the lagged subtract-with-borrow generator.
// ----------------------------------------------------------------------------
package lsbr_pkg;

  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  localparam logic [2:0] LUX_LEVEL0 = 3'd0;
  localparam logic [2:0] LUX_LEVEL1 = 3'd1;
  localparam logic [2:0] LUX_LEVEL2 = 3'd2;
  localparam logic [2:0] LUX_LEVEL3 = 3'd3;
  localparam logic [2:0] LUX_LEVEL4 = 3'd4;

  localparam int SKIP_W = 9;

  localparam logic [31:0] LCG_Q = 32'd53668;
  localparam logic [31:0] LCG_A = 32'd40014;
  localparam logic [31:0] LCG_R = 32'd12211;
  localparam logic [30:0] LCG_RECIP = 31'((64'd1 << 44) / 64'd13417 + 64'd1);

  typedef struct packed {
    logic seed_load;
    logic seed_write;
    logic step_write;
    logic save_word;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic seed_last;
  } stat_t;

  function automatic logic [SKIP_W-1:0] skip_count(input logic [2:0] level);
    logic [SKIP_W-1:0] n;
    case (level)
      LUX_LEVEL0: n = 9'd0;
      LUX_LEVEL1: n = 9'd24;
      LUX_LEVEL2: n = 9'd73;
      LUX_LEVEL3: n = 9'd199;
      LUX_LEVEL4: n = 9'd365;
      default:    n = 9'd199;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

[design/lagged_subtract_borrow_rng.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lagged_subtract_borrow_rng
// Subtract-with-borrow generator over a lag table with luxury discarding.
// ----------------------------------------------------------------------------
// Draw: busy for one table step, any discarded steps, LOW_RD and finish (a
// table step is a registered read and a write); done_o pulses in the cycle
// in which busy is first low. Level 1 discards 24 steps every LAG_WORDS-1 draws.
// Seed: each word passes the LCG pipeline states DIV, MOD, MUL, then WR.
// Results cannot be stalled. After reset the table reads as zero through
// per-word valid flags, so no clearing pass is needed.
module lagged_subtract_borrow_rng #(
  parameter int LAG_WORDS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        operation_i,
  input  wire logic [31:0] seed_value_i,
  input  wire logic        luxury_level_we_i,
  input  wire logic [2:0]  luxury_level_i,
  output logic [63:0]      random_fraction_o,
  output logic             done_o
);
  import lsbr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lsbr_ctrl #(.LAG_WORDS(LAG_WORDS)) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .operation_i       (operation_i),
    .luxury_level_we_i (luxury_level_we_i),
    .luxury_level_i    (luxury_level_i),
    .stat_i            (stat),
    .cmd_o             (cmd),
    .busy_o            (busy_o)
  );

  lsbr_dp #(.LAG_WORDS(LAG_WORDS)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .seed_value_i      (seed_value_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .random_fraction_o (random_fraction_o),
    .done_o            (done_o)
  );

endmodule
`default_nettype wire

[design/lsbr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsbr_ctrl
// Sequencer for seeding, table steps, discarded steps and result hand-off.
// ----------------------------------------------------------------------------
module lsbr_ctrl #(
  parameter int LAG_WORDS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          operation_i,
  input  wire logic          luxury_level_we_i,
  input  wire logic [2:0]    luxury_level_i,
  input  wire lsbr_pkg::stat_t stat_i,
  output lsbr_pkg::cmd_t     cmd_o,
  output logic               busy_o
);
  import lsbr_pkg::*;

  localparam int CNT_W = $clog2(LAG_WORDS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LAG_WORDS - 2);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SEED_DIV = 3'd1;
  localparam logic [2:0] ST_SEED_MOD = 3'd2;
  localparam logic [2:0] ST_SEED_MUL = 3'd3;
  localparam logic [2:0] ST_SEED_WR  = 3'd4;
  localparam logic [2:0] ST_STEP_RD  = 3'd5;
  localparam logic [2:0] ST_STEP_WR  = 3'd6;
  localparam logic [2:0] ST_LOW_RD   = 3'd7;

  logic [2:0]        state_q, state_d;
  logic              is_draw_q, is_draw_d;
  logic              finish_q, finish_d;
  logic [CNT_W-1:0]  draw_cnt_q, draw_cnt_d;
  logic [SKIP_W-1:0] skips_q, skips_d;
  logic [2:0]        lux_q;
  logic              accept;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE) || finish_q;

  always_comb begin
    state_d    = state_q;
    is_draw_d  = is_draw_q;
    draw_cnt_d = draw_cnt_q;
    skips_d    = skips_q;
    finish_d   = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_SEED) begin
            cmd_o.seed_load = 1'b1;
            state_d         = ST_SEED_DIV;
          end else begin
            is_draw_d = 1'b1;
            state_d   = ST_STEP_RD;
          end
        end
      end
      ST_SEED_DIV: state_d = ST_SEED_MOD;
      ST_SEED_MOD: state_d = ST_SEED_MUL;
      ST_SEED_MUL: state_d = ST_SEED_WR;
      ST_SEED_WR: begin
        cmd_o.seed_write = 1'b1;
        state_d = stat_i.seed_last ? ST_IDLE : ST_SEED_DIV;
      end
      ST_STEP_RD: state_d = ST_STEP_WR;
      ST_STEP_WR: begin
        cmd_o.step_write = 1'b1;
        cmd_o.save_word  = is_draw_q;
        is_draw_d        = 1'b0;
        if (is_draw_q) begin
          if (draw_cnt_q == CNT_LAST) begin
            draw_cnt_d = '0;
            skips_d    = skip_count(lux_q);
            state_d    = (skip_count(lux_q) != '0) ? ST_STEP_RD : ST_LOW_RD;
          end else begin
            draw_cnt_d = draw_cnt_q + 1'b1;
            state_d    = ST_LOW_RD;
          end
        end else begin
          skips_d = skips_q - 1'b1;
          state_d = (skips_q == SKIP_W'(1)) ? ST_LOW_RD : ST_STEP_RD;
        end
      end
      ST_LOW_RD: begin
        finish_d = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (finish_q) begin
      cmd_o.finish = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      is_draw_q  <= 1'b0;
      finish_q   <= 1'b0;
      draw_cnt_q <= '0;
      skips_q    <= '0;
      lux_q      <= LUX_LEVEL1;
    end else begin
      state_q    <= state_d;
      is_draw_q  <= is_draw_d;
      finish_q   <= finish_d;
      draw_cnt_q <= draw_cnt_d;
      skips_q    <= skips_d;
      if (luxury_level_we_i) begin
        lux_q <= luxury_level_i;
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (state_q == ST_IDLE))
    else $error("finish issued outside idle");

  a_seed_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.seed_write && stat_i.seed_last) |=> (state_q == ST_IDLE))
    else $error("seeding did not end after the last word");

  a_draw_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_cnt_q <= CNT_LAST)
    else $error("draw counter out of range");

endmodule
`default_nettype wire

[design/lsbr_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsbr_dp
// Lag table, indices, borrow, seeding LCG pipeline and result register.
// ----------------------------------------------------------------------------
module lsbr_dp #(
  parameter int LAG_WORDS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [31:0]   seed_value_i,
  input  wire lsbr_pkg::cmd_t cmd_i,
  output lsbr_pkg::stat_t    stat_o,
  output logic [63:0]        random_fraction_o,
  output logic               done_o
);
  import lsbr_pkg::*;

  localparam int IDX_W = $clog2(LAG_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(LAG_WORDS - 1);
  localparam logic [IDX_W-1:0] FIRST_RST  = IDX_W'(24 % LAG_WORDS);
  localparam logic [IDX_W-1:0] SECOND_RST = IDX_W'(10 % LAG_WORDS);

  logic [31:0]          mem_q [LAG_WORDS];
  logic [LAG_WORDS-1:0] valid_q;
  logic [31:0]          rd_a_q, rd_b_q;
  logic                 va_q, vb_q;
  logic [IDX_W-1:0]     first_q, second_q, seed_idx_q;
  logic                 borrow_q;
  logic [31:0]          word_q;
  logic [63:0]          res_q;
  logic                 done_q;

  logic [31:0] s_q;
  logic [60:0] p_q, p_d;
  logic [16:0] k_q, k_d;
  logic [15:0] rem_q, rem_d;
  logic [31:0] m1_q, m1_d, m2_q, m2_d;
  logic [31:0] km, s_new;

  logic [31:0]      a_word, b_word, r_word, low_word;
  logic [32:0]      sub, diff;
  logic [63:0]      frac;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_data;

  assign p_d   = 61'(s_q[31:2]) * 61'(LCG_RECIP);
  assign k_d   = p_q[60:44];
  assign km    = 32'(k_d) * LCG_Q;
  assign rem_d = 16'(s_q - km);
  assign m1_d  = 32'(rem_q) * LCG_A;
  assign m2_d  = 32'(k_q) * LCG_R;
  assign s_new = m1_q - m2_q;

  assign a_word = va_q ? rd_a_q : 32'd0;
  assign b_word = vb_q ? rd_b_q : 32'd0;
  assign sub    = {1'b0, b_word} + {32'd0, borrow_q};
  assign diff   = {1'b0, a_word} - sub;
  assign r_word = diff[31:0];

  assign low_word = (word_q[31:16] == 16'd0) ? a_word : 32'd0;
  assign frac     = ({word_q, low_word} == 64'd0) ? 64'd1 : {word_q, low_word};

  assign wr_en   = cmd_i.seed_write || cmd_i.step_write;
  assign wr_addr = cmd_i.seed_write ? seed_idx_q : first_q;
  assign wr_data = cmd_i.seed_write ? s_new : r_word;

  assign stat_o.seed_last  = (seed_idx_q == LAST_IDX);
  assign random_fraction_o = res_q;
  assign done_o            = done_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_a_q <= mem_q[second_q];
    rd_b_q <= mem_q[first_q];
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    k_q   <= k_d;
    rem_q <= rem_d;
    m1_q  <= m1_d;
    m2_q  <= m2_d;
    if (cmd_i.seed_load) begin
      s_q <= seed_value_i;
    end else if (cmd_i.seed_write) begin
      s_q <= s_new;
    end
    if (cmd_i.save_word) begin
      word_q <= r_word;
    end
    if (cmd_i.finish) begin
      res_q <= frac;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      va_q       <= 1'b0;
      vb_q       <= 1'b0;
      first_q    <= FIRST_RST;
      second_q   <= SECOND_RST;
      seed_idx_q <= '0;
      borrow_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      va_q   <= valid_q[second_q];
      vb_q   <= valid_q[first_q];
      done_q <= cmd_i.finish;
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.seed_load) begin
        seed_idx_q <= '0;
      end else if (cmd_i.seed_write) begin
        seed_idx_q <= seed_idx_q + 1'b1;
        if (seed_idx_q == LAST_IDX) begin
          first_q  <= LAST_IDX;
          second_q <= SECOND_RST;
          borrow_q <= (s_new == 32'd0);
        end
      end
      if (cmd_i.step_write) begin
        first_q  <= (first_q == '0) ? LAST_IDX : first_q - 1'b1;
        second_q <= (second_q == '0) ? LAST_IDX : second_q - 1'b1;
        borrow_q <= diff[32];
      end
    end
  end

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held longer than one cycle");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (res_q != 64'd0))
    else $error("zero fraction delivered");

  a_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_write |-> (!cmd_i.seed_write && !cmd_i.seed_load))
    else $error("table step overlaps seeding");

endmodule
`default_nettype wire
